// File: hw/rtl/assert_macros.svh
// Assertion macros used by the RTL back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define UVS_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`define UVS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define UVS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define UVS_ASSERT(lbl, cond)
`define UVS_ASSERT_IMP(lbl, ante, cons)
`define UVS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: hw/rtl/uvs_pkg.sv
// Types and constants of the UV sphere mesh generator.
`default_nettype none
package uvs_pkg;

  localparam logic       OP_VERTEX = 1'b0;
  localparam logic       OP_QUAD   = 1'b1;

  localparam logic [1:0] ST_VERTEX = 2'd0;
  localparam logic [1:0] ST_INDEX  = 2'd1;
  localparam logic [1:0] ST_ERROR  = 2'd2;

  localparam logic [1:0] CFG_SEGMENTS = 2'd0;
  localparam logic [1:0] CFG_RINGS    = 2'd1;
  localparam logic [1:0] CFG_RADIUS   = 2'd2;

  localparam int QDEPTH = 4;
  localparam int QPW    = $clog2(QDEPTH);

  // Q30 Taylor coefficients of the quarter-wave sine
  localparam logic [30:0] K1  = 31'd1686629713;
  localparam logic [30:0] K3  = 31'd693598668;
  localparam logic [30:0] K5  = 31'd85569306;
  localparam logic [30:0] K7  = 31'd5026995;
  localparam logic [30:0] K9  = 31'd172272;
  localparam logic [30:0] K11 = 31'd3864;

  typedef enum logic [1:0] {
    JK_VERTEX,
    JK_QUAD,
    JK_ERROR
  } jkind_t;

  typedef struct packed {
    jkind_t      kind;
    logic [7:0]  ring;
    logic [7:0]  seg;
    logic [15:0] idx;
  } job_t;

  typedef struct packed {
    logic [7:0]  segments;
    logic [7:0]  rings;
    logic [15:0] radius;
  } cfg_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_QUAD,
    BS_DIV,
    BS_SIN,
    BS_MUL,
    BS_OUT
  } bstate_t;

endpackage
`default_nettype wire

// File: hw/rtl/uvs_front.sv
// Request front end: range check, classification and base index.
`default_nettype none
module uvs_front (
  input  wire              start,
  input  wire              busy,
  input  wire              opcode,
  input  wire [7:0]        ring,
  input  wire [7:0]        segment,
  input  wire uvs_pkg::cfg_t cfg,
  output logic             push,
  output uvs_pkg::job_t    job
);
  import uvs_pkg::*;

  logic        bad;
  logic [8:0]  row_len;
  logic [16:0] base;

  always_comb begin
    row_len = {1'b0, cfg.segments} + 9'd1;
    base    = 17'(ring * row_len) + {9'd0, segment};
    bad = (cfg.segments == 8'd0) || (cfg.rings == 8'd0) ||
          ((opcode == OP_VERTEX) && ((ring > cfg.rings) || (segment > cfg.segments))) ||
          ((opcode == OP_QUAD) && ((ring >= cfg.rings) || (segment >= cfg.segments)));
    push     = start && !busy;
    job.ring = ring;
    job.seg  = segment;
    job.idx  = base[15:0];
    if (bad) begin
      job.kind = JK_ERROR;
    end else if (opcode == OP_QUAD) begin
      job.kind = JK_QUAD;
    end else begin
      job.kind = JK_VERTEX;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/uvs_queue.sv
// Short job queue between front end and back end.
`default_nettype none
module uvs_queue (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  wire uvs_pkg::job_t wjob,
  input  wire              pop,
  output uvs_pkg::job_t    rjob,
  output logic             not_empty,
  output logic             full
);
  import uvs_pkg::*;

  job_t              mem [QDEPTH];
  logic [QPW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QPW:0]      cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  always_comb begin
    not_empty = (cnt_r != '0);
    full      = (cnt_r == (QPW+1)'(QDEPTH));
    rjob      = mem[rp_r];
    do_push   = push && !full;
    do_pop    = pop && not_empty;
    wp_nxt    = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt    = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt   = cnt_r + (QPW+1)'(do_push) - (QPW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= wjob;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/uvs_back.sv
// Back end: index emission, shared divider and multiplier sequencer for vertices.
`default_nettype none
`include "assert_macros.svh"
module uvs_back #(
  parameter int FRACTION_BITS = 15
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire uvs_pkg::cfg_t   cfg,
  input  wire uvs_pkg::job_t   q_job,
  input  wire                  q_valid,
  output logic                 pop,
  output logic                 out_valid,
  output logic [1:0]           out_status,
  output logic [15:0]          out_vertex_index,
  output logic signed [16:0]   out_pos_x,
  output logic signed [16:0]   out_pos_y,
  output logic signed [16:0]   out_pos_z,
  output logic signed [15:0]   out_norm_x,
  output logic signed [15:0]   out_norm_y,
  output logic signed [15:0]   out_norm_z,
  output logic [16:0]          out_tex_u,
  output logic [16:0]          out_tex_v,
  output logic                 out_last
);
  import uvs_pkg::*;

  localparam int F  = FRACTION_BITS;
  localparam int MW = 2*F + 1;   // product of two trig magnitudes
  localparam int AW = 2*F + 17;  // product times radius
  localparam int NW = 2*F + 2;
  localparam int DNW = 41;
  localparam logic [5:0] DIV_LAST = 6'(DNW - 1);
  localparam logic [1:0] DIV_THETA = 2'd0;
  localparam logic [1:0] DIV_PHI   = 2'd1;
  localparam logic [1:0] DIV_TEXU  = 2'd2;
  localparam logic [1:0] DIV_TEXV  = 2'd3;
  localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
  localparam logic [31:0] QUARTER  = 32'h4000_0000;

  function automatic logic [DNW-1:0] div_num(input logic [1:0] sel,
                                             input logic [7:0] r, s, sg, rg);
    case (sel)
      DIV_THETA: div_num = {1'b0, s, 24'd0, 1'b0, sg[7:1]};
      DIV_PHI:   div_num = {1'b0, r, 24'd0, rg};
      DIV_TEXU:  div_num = DNW'({s, 8'd0, 1'b0, sg[7:1]});
      default:   div_num = DNW'({r, 8'd0, 1'b0, rg[7:1]});
    endcase
  endfunction

  bstate_t           state_r, state_nxt;
  logic [2:0]        k_r, k_nxt;
  job_t              job_r, job_nxt;

  logic [1:0]        dsel_r, dsel_nxt;
  logic [5:0]        dcnt_r, dcnt_nxt;
  logic [DNW-1:0]    dnum_r, dnum_nxt, dquo_r, dquo_nxt;
  logic [8:0]        drem_r, drem_nxt;
  logic [31:0]       theta_r, theta_nxt, phi_r, phi_nxt;
  logic [16:0]       texu_r, texu_nxt, texv_r, texv_nxt;

  logic [1:0]        ssel_r, ssel_nxt, qd_r, qd_nxt;
  logic [2:0]        sstep_r, sstep_nxt;
  logic [30:0]       u_r, u_nxt, u2_r, u2_nxt, a_r, a_nxt;
  logic [F:0]        tm_r [4];
  logic [F:0]        tm_nxt [4];
  logic [3:0]        tn_r, tn_nxt;

  logic [2:0]        pstep_r, pstep_nxt;
  logic [MW-1:0]     xm_r, xm_nxt, zm_r, zm_nxt;
  logic [AW-1:0]     acc_r, acc_nxt;
  logic [16:0]       px_r, px_nxt, py_r, py_nxt, pz_r, pz_nxt;

  logic              ov_r, ov_nxt, ol_r, ol_nxt;
  logic [1:0]        os_r, os_nxt;
  logic [15:0]       oi_r, oi_nxt;
  logic [16:0]       opx_r, opx_nxt, opy_r, opy_nxt, opz_r, opz_nxt;
  logic [15:0]       onx_r, onx_nxt, ony_r, ony_nxt, onz_r, onz_nxt;
  logic [16:0]       otu_r, otu_nxt, otv_r, otv_nxt;

  // shared datapath
  logic [30:0]       mul_a, mul_b;
  logic [61:0]       mul_p;
  logic [8:0]        dvs;
  logic [9:0]        trial;
  logic              ge;
  logic [31:0]       phase, asub;
  logic [30:0]       u_c, kc;
  logic [32:0]       vr, mfull;
  logic [MW-1:0]     ym, msel;
  logic [60:0]       mext;
  logic [AW-1:0]     tot, pround;
  logic [16:0]       pm;
  logic              xn, yn, zn, psign;
  logic [15:0]       row1, ci;
  logic [NW-1:0]     nsx, nsy, nsz;
  logic [16:0]       nmx, nmy, nmz;
  logic [14:0]       ncx, ncy, ncz;

  assign mul_p = mul_a * mul_b;

  always_comb begin
    ym    = MW'(tm_r[3]) << F;
    xn    = tn_r[1] ^ tn_r[2];
    zn    = tn_r[0] ^ tn_r[2];
    yn    = !tn_r[3];
    nsx   = NW'(xm_r) + (NW'(1) << (2*F - 16));
    nsy   = NW'(ym)   + (NW'(1) << (2*F - 16));
    nsz   = NW'(zm_r) + (NW'(1) << (2*F - 16));
    nmx   = 17'(nsx >> (2*F - 15));
    nmy   = 17'(nsy >> (2*F - 15));
    nmz   = 17'(nsz >> (2*F - 15));
    ncx   = (nmx > 17'd32767) ? 15'h7fff : nmx[14:0];
    ncy   = (nmy > 17'd32767) ? 15'h7fff : nmy[14:0];
    ncz   = (nmz > 17'd32767) ? 15'h7fff : nmz[14:0];
    row1  = {8'd0, cfg.segments} + 16'd1;
  end

  always_comb begin
    state_nxt = state_r;  k_nxt = k_r;  job_nxt = job_r;
    dsel_nxt = dsel_r;  dcnt_nxt = dcnt_r;  dnum_nxt = dnum_r;
    dquo_nxt = dquo_r;  drem_nxt = drem_r;
    theta_nxt = theta_r;  phi_nxt = phi_r;  texu_nxt = texu_r;  texv_nxt = texv_r;
    ssel_nxt = ssel_r;  qd_nxt = qd_r;  sstep_nxt = sstep_r;
    u_nxt = u_r;  u2_nxt = u2_r;  a_nxt = a_r;  tm_nxt = tm_r;  tn_nxt = tn_r;
    pstep_nxt = pstep_r;  xm_nxt = xm_r;  zm_nxt = zm_r;  acc_nxt = acc_r;
    px_nxt = px_r;  py_nxt = py_r;  pz_nxt = pz_r;
    ov_nxt = 1'b0;  ol_nxt = ol_r;  os_nxt = os_r;  oi_nxt = oi_r;
    opx_nxt = opx_r;  opy_nxt = opy_r;  opz_nxt = opz_r;
    onx_nxt = onx_r;  ony_nxt = ony_r;  onz_nxt = onz_r;
    otu_nxt = otu_r;  otv_nxt = otv_r;
    pop = 1'b0;
    mul_a = '0;  mul_b = '0;

    case (dsel_r)
      DIV_PHI:  dvs = {cfg.rings, 1'b0};
      DIV_TEXV: dvs = {1'b0, cfg.rings};
      default:  dvs = {1'b0, cfg.segments};
    endcase
    trial = {drem_r, dnum_r[DNW-1]};
    ge    = trial >= {1'b0, dvs};

    case (ssel_r)
      2'd0:    phase = theta_r;
      2'd1:    phase = theta_r + QUARTER;
      2'd2:    phase = phi_r;
      default: phase = phi_r + QUARTER;
    endcase
    u_c = phase[30] ? Q30_ONE - {1'b0, phase[29:0]} : {1'b0, phase[29:0]};
    case (sstep_r)
      3'd1:    kc = K9;
      3'd2:    kc = K7;
      3'd3:    kc = K5;
      3'd4:    kc = K3;
      default: kc = K1;
    endcase
    asub  = {1'b0, kc} - mul_p[61:30];
    vr    = {1'b0, mul_p[61:30]} + (33'd1 << (29 - F));
    mfull = vr >> (30 - F);

    case (pstep_r)
      3'd2, 3'd3: begin msel = xm_r; psign = xn; end
      3'd4, 3'd5: begin msel = ym;   psign = yn; end
      default:    begin msel = zm_r; psign = zn; end
    endcase
    mext   = 61'(msel);
    tot    = acc_r + (AW'(mul_p) << 30);
    pround = (tot + (AW'(1) << (2*F - 1))) >> (2*F);
    pm     = (psign && pround[16:0] != 17'd0) ? -pround[16:0] : pround[16:0];

    case (k_r)
      3'd1:    ci = job_r.idx + row1;
      3'd2:    ci = job_r.idx + row1 + 16'd1;
      3'd3:    ci = job_r.idx;
      3'd4:    ci = job_r.idx + row1 + 16'd1;
      default: ci = job_r.idx + 16'd1;
    endcase

    case (state_r)
      BS_IDLE: begin
        if (q_valid) begin
          pop     = 1'b1;
          job_nxt = q_job;
          opx_nxt = '0;  opy_nxt = '0;  opz_nxt = '0;
          onx_nxt = '0;  ony_nxt = '0;  onz_nxt = '0;
          otu_nxt = '0;  otv_nxt = '0;
          case (q_job.kind)
            JK_QUAD: begin
              ov_nxt = 1'b1;  os_nxt = ST_INDEX;  oi_nxt = q_job.idx;  ol_nxt = 1'b0;
              k_nxt = 3'd1;
              state_nxt = BS_QUAD;
            end
            JK_VERTEX: begin
              dsel_nxt = DIV_THETA;  dcnt_nxt = '0;  drem_nxt = '0;  dquo_nxt = '0;
              dnum_nxt = div_num(DIV_THETA, q_job.ring, q_job.seg, cfg.segments, cfg.rings);
              state_nxt = BS_DIV;
            end
            default: begin
              ov_nxt = 1'b1;  os_nxt = ST_ERROR;  oi_nxt = '0;  ol_nxt = 1'b1;
            end
          endcase
        end
      end
      BS_QUAD: begin
        ov_nxt = 1'b1;  os_nxt = ST_INDEX;  oi_nxt = ci;
        ol_nxt = (k_r == 3'd5);
        k_nxt  = k_r + 3'd1;
        if (k_r == 3'd5) begin
          state_nxt = BS_IDLE;
        end
      end
      BS_DIV: begin
        if (dcnt_r == DIV_LAST) begin
          case (dsel_r)
            DIV_THETA: theta_nxt = dquo_nxt[31:0];
            DIV_PHI:   phi_nxt   = dquo_nxt[31:0];
            DIV_TEXU:  texu_nxt  = dquo_nxt[16:0];
            default:   texv_nxt  = dquo_nxt[16:0];
          endcase
        end
        dquo_nxt = {dquo_r[DNW-2:0], ge};
        case (dsel_r)
          DIV_THETA: theta_nxt = (dcnt_r == DIV_LAST) ? dquo_nxt[31:0] : theta_r;
          DIV_PHI:   phi_nxt   = (dcnt_r == DIV_LAST) ? dquo_nxt[31:0] : phi_r;
          DIV_TEXU:  texu_nxt  = (dcnt_r == DIV_LAST) ? dquo_nxt[16:0] : texu_r;
          default:   texv_nxt  = (dcnt_r == DIV_LAST) ? dquo_nxt[16:0] : texv_r;
        endcase
        if (dcnt_r == DIV_LAST) begin
          dcnt_nxt = '0;  drem_nxt = '0;  dquo_nxt = '0;
          if (dsel_r == DIV_TEXV) begin
            ssel_nxt = 2'd0;  sstep_nxt = 3'd0;
            state_nxt = BS_SIN;
          end else begin
            dsel_nxt = dsel_r + 2'd1;
            dnum_nxt = div_num(dsel_r + 2'd1, job_r.ring, job_r.seg,
                               cfg.segments, cfg.rings);
          end
        end else begin
          drem_nxt = ge ? 9'(trial - {1'b0, dvs}) : trial[8:0];
          dnum_nxt = dnum_r << 1;
          dcnt_nxt = dcnt_r + 6'd1;
        end
      end
      BS_SIN: begin
        sstep_nxt = sstep_r + 3'd1;
        case (sstep_r)
          3'd0: begin
            mul_a = u_c;  mul_b = u_c;
            u_nxt = u_c;  qd_nxt = phase[31:30];
            u2_nxt = mul_p[60:30];
          end
          3'd1: begin
            mul_a = u2_r;  mul_b = K11;
            a_nxt = asub[30:0];
          end
          3'd6: begin
            mul_a = u_r;  mul_b = a_r;
            tm_nxt[ssel_r] = (mfull > (33'd1 << F)) ? (F+1)'(1) << F : mfull[F:0];
            tn_nxt[ssel_r] = qd_r[1] && (mfull != 33'd0);
            sstep_nxt = 3'd0;
            ssel_nxt  = ssel_r + 2'd1;
            if (ssel_r == 2'd3) begin
              pstep_nxt = 3'd0;
              state_nxt = BS_MUL;
            end
          end
          default: begin
            mul_a = u2_r;  mul_b = a_r;
            a_nxt = asub[30:0];
          end
        endcase
      end
      BS_MUL: begin
        pstep_nxt = pstep_r + 3'd1;
        case (pstep_r)
          3'd0: begin
            mul_a = 31'(tm_r[1]);  mul_b = 31'(tm_r[2]);
            xm_nxt = mul_p[MW-1:0];
          end
          3'd1: begin
            mul_a = 31'(tm_r[0]);  mul_b = 31'(tm_r[2]);
            zm_nxt = mul_p[MW-1:0];
          end
          3'd2, 3'd4, 3'd6: begin
            mul_a = {1'b0, mext[29:0]};  mul_b = {15'd0, cfg.radius};
            acc_nxt = AW'(mul_p);
          end
          default: begin
            mul_a = mext[60:30];  mul_b = {15'd0, cfg.radius};
            case (pstep_r)
              3'd3:    px_nxt = pm;
              3'd5:    py_nxt = pm;
              default: begin
                pz_nxt = pm;
                state_nxt = BS_OUT;
              end
            endcase
          end
        endcase
      end
      BS_OUT: begin
        ov_nxt = 1'b1;  os_nxt = ST_VERTEX;  oi_nxt = job_r.idx;  ol_nxt = 1'b1;
        opx_nxt = px_r;  opy_nxt = py_r;  opz_nxt = pz_r;
        onx_nxt = (xn && ncx != '0) ? -{1'b0, ncx} : {1'b0, ncx};
        ony_nxt = (yn && ncy != '0) ? -{1'b0, ncy} : {1'b0, ncy};
        onz_nxt = (zn && ncz != '0) ? -{1'b0, ncz} : {1'b0, ncz};
        otu_nxt = texu_r;  otv_nxt = texv_r;
        state_nxt = BS_IDLE;
      end
      default: state_nxt = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BS_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r <= k_nxt;  job_r <= job_nxt;
    dsel_r <= dsel_nxt;  dcnt_r <= dcnt_nxt;  dnum_r <= dnum_nxt;
    dquo_r <= dquo_nxt;  drem_r <= drem_nxt;
    theta_r <= theta_nxt;  phi_r <= phi_nxt;  texu_r <= texu_nxt;  texv_r <= texv_nxt;
    ssel_r <= ssel_nxt;  qd_r <= qd_nxt;  sstep_r <= sstep_nxt;
    u_r <= u_nxt;  u2_r <= u2_nxt;  a_r <= a_nxt;  tm_r <= tm_nxt;  tn_r <= tn_nxt;
    pstep_r <= pstep_nxt;  xm_r <= xm_nxt;  zm_r <= zm_nxt;  acc_r <= acc_nxt;
    px_r <= px_nxt;  py_r <= py_nxt;  pz_r <= pz_nxt;
    ol_r <= ol_nxt;  os_r <= os_nxt;  oi_r <= oi_nxt;
    opx_r <= opx_nxt;  opy_r <= opy_nxt;  opz_r <= opz_nxt;
    onx_r <= onx_nxt;  ony_r <= ony_nxt;  onz_r <= onz_nxt;
    otu_r <= otu_nxt;  otv_r <= otv_nxt;
  end

  assign out_valid        = ov_r;
  assign out_status       = os_r;
  assign out_vertex_index = oi_r;
  assign out_pos_x        = opx_r;
  assign out_pos_y        = opy_r;
  assign out_pos_z        = opz_r;
  assign out_norm_x       = onx_r;
  assign out_norm_y       = ony_r;
  assign out_norm_z       = onz_r;
  assign out_tex_u        = otu_r;
  assign out_tex_v        = otv_r;
  assign out_last         = ol_r;

  `UVS_ASSERT(a_vertex_last, !(ov_r && os_r == ST_VERTEX) || ol_r)
  `UVS_ASSERT_IMP(a_quad_emits, state_r == BS_QUAD, ov_r && os_r == ST_INDEX)
  `UVS_ASSERT_NEXT(a_quad_done, state_r == BS_QUAD && k_r == 3'd5, state_r == BS_IDLE)

endmodule
`default_nettype wire

// File: hw/rtl/uv_sphere_mesh_generator.sv
// Top level of the UV sphere mesh generator.
//
//  channel  handshake        payload
//  in       start / busy     in_opcode, in_ring, in_segment
//  out      out_valid strobe out_status ... out_last
//  cfg      cfg_we           cfg_index, cfg_data
//
// A quad gives six indices, one index a cycle; an error gives one result; a vertex
// runs four divisions with 41-bit quotients on the shared bit-serial divider, then
// steps on the shared 31x31 multiplier (four sines, products, radius scaling).
// Requests queue 4 deep in front of the back end; busy is high while it is full.
// Reset is synchronous, active low: queue and sequencer empty, registers to
// 16 segments, 16 rings, radius 1.0. Results are strobed and cannot be held off.
`default_nettype none
module uv_sphere_mesh_generator #(
  parameter int FRACTION_BITS = 15
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  input  wire                in_opcode,
  input  wire [7:0]          in_ring,
  input  wire [7:0]          in_segment,
  input  wire                cfg_we,
  input  wire [1:0]          cfg_index,
  input  wire [15:0]         cfg_data,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [15:0]        out_vertex_index,
  output logic signed [16:0] out_pos_x,
  output logic signed [16:0] out_pos_y,
  output logic signed [16:0] out_pos_z,
  output logic signed [15:0] out_norm_x,
  output logic signed [15:0] out_norm_y,
  output logic signed [15:0] out_norm_z,
  output logic [16:0]        out_tex_u,
  output logic [16:0]        out_tex_v,
  output logic               out_last
);
  import uvs_pkg::*;

  cfg_t  cfg_r, cfg_nxt;
  job_t  fjob, qjob;
  logic  push, pop, q_valid, q_full;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_SEGMENTS: cfg_nxt.segments = cfg_data[7:0];
        CFG_RINGS:    cfg_nxt.rings    = cfg_data[7:0];
        CFG_RADIUS:   cfg_nxt.radius   = cfg_data;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.segments <= 8'd16;
      cfg_r.rings    <= 8'd16;
      cfg_r.radius   <= 16'd256;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign busy = q_full;

  uvs_front u_front (
    .start   (start),
    .busy    (busy),
    .opcode  (in_opcode),
    .ring    (in_ring),
    .segment (in_segment),
    .cfg     (cfg_r),
    .push    (push),
    .job     (fjob)
  );

  uvs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wjob      (fjob),
    .pop       (pop),
    .rjob      (qjob),
    .not_empty (q_valid),
    .full      (q_full)
  );

  uvs_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_job            (qjob),
    .q_valid          (q_valid),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_vertex_index (out_vertex_index),
    .out_pos_x        (out_pos_x),
    .out_pos_y        (out_pos_y),
    .out_pos_z        (out_pos_z),
    .out_norm_x       (out_norm_x),
    .out_norm_y       (out_norm_y),
    .out_norm_z       (out_norm_z),
    .out_tex_u        (out_tex_u),
    .out_tex_v        (out_tex_v),
    .out_last         (out_last)
  );

endmodule
`default_nettype wire
